[src/fdr_pkg.sv]
// Package for the duplicate-id rejecting FIFO: constants, opcodes and payload structs.
`default_nettype none

package fdr_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ID_W  = 31;
   localparam int PAY_W = 32;
   localparam int OUT_CNT_W = 5;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_PULL  = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } fdr_op_type;

   typedef struct packed {
      fdr_op_type         req_type;
      logic signed [31:0] item_id;
      logic [31:0]        payload;
      logic               payload_empty;
   } fdr_req_type;

   typedef struct packed {
      logic                 success;
      logic [ID_W-1:0]      out_id;
      logic [PAY_W-1:0]     out_payload;
      logic [OUT_CNT_W-1:0] entry_count;
      logic                 queue_empty;
   } fdr_rsp_type;

   // One stored entry as it moves along the cell row.
   typedef struct packed {
      logic             valid;
      logic [ID_W-1:0]  id;
      logic [PAY_W-1:0] payload;
   } fdr_entry_type;

   // Per-cell control from the queue controller.
   typedef struct packed {
      logic clear;
      logic shift;
      logic load;
   } fdr_cell_ctrl_type;

endpackage

`default_nettype wire

[src/fdr_cell.sv]
// One storage cell of the queue row: holds an entry, shifts toward the head, matches ids.
`default_nettype none

module fdr_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  fdr_pkg::fdr_cell_ctrl_type ctrl,
   input  fdr_pkg::fdr_entry_type   up_entry,
   input  fdr_pkg::fdr_entry_type   new_entry,
   input  wire [fdr_pkg::ID_W-1:0]  key,
   output fdr_pkg::fdr_entry_type   cur_entry,
   output logic                     match
);
   import fdr_pkg::*;

   logic             valid_ff, valid_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [PAY_W-1:0] payload_ff, payload_in;

   always_comb begin
      valid_in   = valid_ff;
      id_in      = id_ff;
      payload_in = payload_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_in   = up_entry.valid;
         id_in      = up_entry.id;
         payload_in = up_entry.payload;
      end else if (ctrl.load) begin
         valid_in   = 1'b1;
         id_in      = new_entry.id;
         payload_in = new_entry.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      payload_ff <= payload_in;
   end

   assign cur_entry = '{valid: valid_ff, id: id_ff, payload: payload_ff};
   assign match     = valid_ff && (id_ff == key);

endmodule

`default_nettype wire

[src/fifo_with_duplicate_id_reject.sv]
// Top level of the bounded FIFO that rejects pushes of ids already held.
`default_nettype none

// Bounded queue of DEPTH (id, payload) entries kept in a row of cells with the
// head in cell 0. Every request (push, pull, peek, clear) is taken when start is
// high and answered with exactly one result in the next cycle: busy never rises,
// so a request may be issued every clock. The id compare is done by every cell
// at once against the pushed id and feeds a single OR across the row. The
// result is shown for one cycle under rsp_strobe and cannot be held off, so
// capture it on that edge. A push fails when the id is negative, the payload is
// marked empty, the queue is full or the id is already held; a failed push
// changes nothing. Pull and peek on an empty queue fail. out_id and out_payload
// are zero except for a successful pull or peek. entry_count and queue_empty
// give the state after the request.
module fifo_with_duplicate_id_reject (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  fdr_pkg::fdr_req_type  req_data,
   output logic                  rsp_strobe,
   output fdr_pkg::fdr_rsp_type  rsp_data
);
   import fdr_pkg::*;

   fdr_entry_type     cell_entry [DEPTH];
   fdr_entry_type     up_entry   [DEPTH];
   fdr_cell_ctrl_type cell_ctrl  [DEPTH];
   logic [DEPTH-1:0]  cell_match;
   logic [DEPTH-1:0]  cell_valid;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_strobe_ff;
   fdr_rsp_type       rsp_ff, rsp_in;

   logic              accept;
   logic              is_push, is_pull, is_peek, is_clear;
   logic              dup_hit, push_ok, head_ok, pull_ok;
   logic [ID_W-1:0]   key;
   fdr_entry_type     new_entry;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign is_push  = accept && (req_data.req_type == OP_PUSH);
   assign is_pull  = accept && (req_data.req_type == OP_PULL);
   assign is_peek  = accept && (req_data.req_type == OP_PEEK);
   assign is_clear = accept && (req_data.req_type == OP_CLEAR);

   assign key       = req_data.item_id[ID_W-1:0];
   assign new_entry = '{valid: 1'b1, id: key, payload: req_data.payload};

   // Every cell checks the pushed id against its own entry.
   assign dup_hit = |cell_match;
   assign push_ok = is_push && !req_data.item_id[31] && !req_data.payload_empty
                    && (count_ff < CNT_W'(DEPTH)) && !dup_hit;
   assign head_ok = (is_pull || is_peek) && (count_ff != '0);
   assign pull_ok = is_pull && head_ok;

   // Build the row: each cell takes its upper neighbor's entry on a pull.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_last
         assign up_entry[i] = '0;
      end else begin : g_mid
         assign up_entry[i] = cell_entry[i+1];
      end

      assign cell_ctrl[i] = '{clear: is_clear,
                              shift: pull_ok,
                              load:  push_ok && (count_ff == CNT_W'(i))};

      fdr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl[i]),
         .up_entry  (up_entry[i]),
         .new_entry (new_entry),
         .key       (key),
         .cur_entry (cell_entry[i]),
         .match     (cell_match[i])
      );

      assign cell_valid[i] = cell_entry[i].valid;
   end

   // Advance the fill count.
   always_comb begin
      count_in = count_ff;
      if (is_clear) begin
         count_in = '0;
      end else if (push_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pull_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Form the result from the state before the update and the new count.
   always_comb begin
      rsp_in             = '0;
      rsp_in.success     = push_ok || head_ok || is_clear;
      rsp_in.entry_count = OUT_CNT_W'(count_in);
      rsp_in.queue_empty = (count_in == '0);
      if (head_ok) begin
         rsp_in.out_id      = cell_entry[0].id;
         rsp_in.out_payload = cell_entry[0].payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   // Hold the result payload for the transfer cycle.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Every transfer in produces one result on the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("result strobe missing after accepted request");

   // Valid cells always equal the fill count.
   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == 32'(count_ff))
      else $error("cell valid bits disagree with fill count");

   // The count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above capacity");

   // A clear always reports an empty queue.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      is_clear |=> (rsp_data.success && rsp_data.queue_empty))
      else $error("clear did not report an empty queue");

endmodule

`default_nettype wire
